>>> rtl/affine_block_transposition_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the affine block transposition core
// Shared helpers for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef AFFINE_BLOCK_TRANSPOSITION_CORE_DEFINES_SVH
`define AFFINE_BLOCK_TRANSPOSITION_CORE_DEFINES_SVH

// same-cycle implication
`define ABT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ABT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/abt_pkg.sv
// ----------------------------------------------------------------------------
// Affine block transposition package
// Field widths, register indexes, output codes and controller/datapath links.
// ----------------------------------------------------------------------------
package abt_pkg;

   localparam int CHAR_W     = 8;
   localparam int BLEN_W     = 6;
   localparam int COEF_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MULT_A    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_B  = 2'd2;

   localparam logic [CHAR_W-1:0] ZERO_SHOWN   = 8'd224;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

   typedef struct packed {
      logic write_char;
      logic capture_full;
      logic capture_end;
      logic mod_step;
      logic blk_start;
      logic issue_byte;
      logic issue_nl;
   } cmd_type;

   typedef struct packed {
      logic full_next;
      logic fill_zero;
      logic dirty;
      logic mod_last;
      logic issue_ok;
      logic last_pos;
      logic end_line;
   } status_type;

endpackage

>>> rtl/abt_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one character or an end-of-line marker.
// ----------------------------------------------------------------------------
interface abt_req_if
   import abt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              line_end;

   modport source (output valid, output char_in, output line_end, input ready);
   modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

>>> rtl/abt_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one permuted byte or the newline code.
// ----------------------------------------------------------------------------
interface abt_rsp_if
   import abt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic              last;

   modport source (output valid, output char_out, output last, input ready);
   modport sink   (input valid, input char_out, input last, output ready);
endinterface

>>> rtl/abt_ctrl.sv
// ----------------------------------------------------------------------------
// Affine block transposition controller
// Sequences capture, residue update, block emission and newline issue.
// ----------------------------------------------------------------------------
module abt_ctrl
   import abt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_line_end,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MOD  = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_EMIT = 5'b01000,
      ST_TAIL = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_line_end) begin
                  cmd.write_char = 1'b1;
                  if (status.full_next) begin
                     cmd.capture_full = 1'b1;
                     if (status.dirty) begin
                        state_in = ST_MOD;
                     end else begin
                        cmd.blk_start = 1'b1;
                        state_in      = ST_EMIT;
                     end
                  end
               end else if (!status.fill_zero) begin
                  cmd.capture_end = 1'b1;
                  if (status.dirty) begin
                     state_in = ST_MOD;
                  end else begin
                     cmd.blk_start = 1'b1;
                     state_in      = ST_EMIT;
                  end
               end else begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.blk_start = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.issue_ok) begin
               cmd.issue_byte = 1'b1;
               if (status.last_pos) begin
                  state_in = status.end_line ? ST_TAIL : ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            if (status.issue_ok) begin
               cmd.issue_nl = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/abt_datapath.sv
// ----------------------------------------------------------------------------
// Affine block transposition datapath
// Settings, block buffer, residue unit, index walk and output pipeline.
// ----------------------------------------------------------------------------
module abt_datapath
   import abt_pkg::*;
#(
   parameter int MAX_BLOCK = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [CHAR_W-1:0]     req_char_in,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [CHAR_W-1:0]     rsp_char_out,
   output logic                  rsp_last
);

   localparam int CW   = $clog2(MAX_BLOCK + 1);
   localparam int IW   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int MCW  = $clog2(COEF_W);

   logic [BLEN_W-1:0] blk_len_ff;
   logic [COEF_W-1:0] mult_a_ff;
   logic [COEF_W-1:0] offset_b_ff;
   logic              dirty_ff;
   logic [CW-1:0]     fill_ff;
   logic [CW-1:0]     filled_ff;
   logic              eol_ff;
   logic [MCW-1:0]    mod_cnt_ff;
   logic [CW-1:0]     a_mod_ff, a_mod_in;
   logic [CW-1:0]     b_mod_ff, b_mod_in;
   logic [CW-1:0]     src_ff, src_in;
   logic [CW-1:0]     j_ff;
   logic [CHAR_W-1:0] blk_mem [MAX_BLOCK];
   logic [CHAR_W-1:0] rd_ff;
   logic              s1_valid_ff;
   logic              s1_pad_ff;
   logic              s1_nl_ff;
   logic              s1_last_ff;
   logic              out_valid_ff;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_last_ff;

   logic [CW-1:0]     n_len;
   logic [CW:0]       fill_inc;
   logic              out_free;
   logic [MCW-1:0]    bit_sel;
   logic [CW-1:0]     a_base, b_base;
   logic [CW:0]       a_shift, b_shift;
   logic [CW:0]       src_sum;

   always_comb begin
      if (blk_len_ff == '0) begin
         n_len = CW'(1);
      end else if (blk_len_ff > BLEN_W'(MAX_BLOCK)) begin
         n_len = CW'(MAX_BLOCK);
      end else begin
         n_len = CW'(blk_len_ff);
      end
   end

   assign fill_inc = {1'b0, fill_ff} + (CW + 1)'(1);
   assign out_free = !out_valid_ff || rsp_ready;

   assign status.full_next = (fill_inc >= {1'b0, n_len});
   assign status.fill_zero = (fill_ff == '0);
   assign status.dirty     = dirty_ff;
   assign status.mod_last  = (mod_cnt_ff == MCW'(COEF_W - 1));
   assign status.issue_ok  = !s1_valid_ff || out_free;
   assign status.last_pos  = (j_ff == n_len - CW'(1));
   assign status.end_line  = eol_ff;

   // restoring residue of mult_a and offset_b by the block length, one bit a step
   assign bit_sel = MCW'(COEF_W - 1) - mod_cnt_ff;
   assign a_base  = (mod_cnt_ff == '0) ? '0 : a_mod_ff;
   assign b_base  = (mod_cnt_ff == '0) ? '0 : b_mod_ff;
   assign a_shift = {a_base, mult_a_ff[bit_sel]};
   assign b_shift = {b_base, offset_b_ff[bit_sel]};

   always_comb begin
      a_mod_in = CW'(a_shift);
      b_mod_in = CW'(b_shift);
      if (a_shift >= {1'b0, n_len}) begin
         a_mod_in = CW'(a_shift - {1'b0, n_len});
      end
      if (b_shift >= {1'b0, n_len}) begin
         b_mod_in = CW'(b_shift - {1'b0, n_len});
      end
   end

   // advance source index by mult_a modulo block length
   assign src_sum = {1'b0, src_ff} + {1'b0, a_mod_ff};
   always_comb begin
      src_in = CW'(src_sum);
      if (src_sum >= {1'b0, n_len}) begin
         src_in = CW'(src_sum - {1'b0, n_len});
      end
   end

   always_comb begin
      if (s1_nl_ff) begin
         out_char_in = NEWLINE_CODE;
      end else if (s1_pad_ff || rd_ff == '0) begin
         out_char_in = ZERO_SHOWN;
      end else begin
         out_char_in = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_len_ff  <= BLEN_W'(1);
         mult_a_ff   <= COEF_W'(1);
         offset_b_ff <= '0;
         dirty_ff    <= 1'b1;
         fill_ff     <= '0;
         mod_cnt_ff  <= '0;
      end else begin
         if (csr_we) begin
            dirty_ff <= 1'b1;
            unique case (csr_index)
               CSR_BLOCK_LEN: blk_len_ff  <= csr_wdata[BLEN_W-1:0];
               CSR_MULT_A:    mult_a_ff   <= csr_wdata[COEF_W-1:0];
               CSR_OFFSET_B:  offset_b_ff <= csr_wdata[COEF_W-1:0];
               default: begin
               end
            endcase
         end else if (cmd.mod_step && status.mod_last) begin
            dirty_ff <= 1'b0;
         end
         priority if (csr_we && csr_index == CSR_BLOCK_LEN) begin
            fill_ff <= '0;
         end else if (cmd.capture_full || cmd.capture_end) begin
            fill_ff <= '0;
         end else if (cmd.write_char) begin
            fill_ff <= CW'(fill_inc);
         end
         if (cmd.mod_step) begin
            mod_cnt_ff <= mod_cnt_ff + MCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mod_step) begin
         a_mod_ff <= a_mod_in;
         b_mod_ff <= b_mod_in;
      end
      if (cmd.capture_full) begin
         filled_ff <= n_len;
         eol_ff    <= 1'b0;
      end else if (cmd.capture_end) begin
         filled_ff <= fill_ff;
         eol_ff    <= 1'b1;
      end
      if (cmd.blk_start) begin
         src_ff <= b_mod_ff;
         j_ff   <= '0;
      end else if (cmd.issue_byte) begin
         src_ff <= src_in;
         j_ff   <= j_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_char) begin
         blk_mem[fill_ff[IW-1:0]] <= req_char_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue_byte) begin
         rd_ff <= blk_mem[src_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue_byte) begin
         s1_pad_ff  <= (src_ff >= filled_ff);
         s1_nl_ff   <= 1'b0;
         s1_last_ff <= status.last_pos && !eol_ff;
      end else if (cmd.issue_nl) begin
         s1_pad_ff  <= 1'b0;
         s1_nl_ff   <= 1'b1;
         s1_last_ff <= 1'b1;
      end
      if (out_free) begin
         out_char_ff <= out_char_in;
         out_last_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.issue_byte || cmd.issue_nl) begin
            s1_valid_ff <= 1'b1;
         end else if (out_free) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_free) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_char_out = out_char_ff;
   assign rsp_last     = out_last_ff;

endmodule

>>> rtl/affine_block_transposition_core.sv
// ----------------------------------------------------------------------------
// Affine block transposition core
// Buffers line bytes into blocks and sends each block out in affine order.
// ----------------------------------------------------------------------------
//   channel   dir   handshake       payload
//   req_chan  in    valid/ready     char_in[7:0], line_end
//   rsp_chan  out   valid/ready     char_out[7:0], last
//   csr_*     in    csr_we          csr_index[1:0], csr_wdata[7:0]
//
// A byte that does not fill a block is only written to the buffer. A full
// block of n bytes is then sent, one buffer read per cycle unless stalled,
// through a two-entry output pipeline, and a newline at end of line. After
// reset or any register write the residue unit runs first, one bit per cycle.
// Synchronous reset; the buffer needs no clearing. A stalled response holds
// the pipeline and the core takes no request while a block is being sent.
// ----------------------------------------------------------------------------
module affine_block_transposition_core
   import abt_pkg::*;
#(
   parameter int MAX_BLOCK = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   abt_req_if.sink               req_chan,
   abt_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;
   logic [CHAR_W-1:0] rsp_char_out;
   logic       rsp_last;

   abt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_line_end (req_chan.line_end),
      .req_ready    (req_ready),
      .status       (status),
      .cmd          (cmd)
   );

   abt_datapath #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_char_in  (req_chan.char_in),
      .cmd          (cmd),
      .status       (status),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_valid),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

   assign req_chan.ready    = req_ready;
   assign rsp_chan.valid    = rsp_valid;
   assign rsp_chan.char_out = rsp_char_out;
   assign rsp_chan.last     = rsp_last;

endmodule

>>> rtl/abt_checker.sv
// ----------------------------------------------------------------------------
// Affine block transposition port checker
// Concurrent checks on the core's channels, attached by bind.
// ----------------------------------------------------------------------------
`include "affine_block_transposition_core_defines.svh"

module abt_checker
   import abt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_line_end,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAR_W-1:0] rsp_char_out,
   input logic              rsp_last
);

   `ABT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_char_out) && $stable(rsp_last), "stalled response transfer changed")
   `ABT_ASSERT_NOW(a_no_zero, clock, reset, rsp_valid, rsp_char_out != '0, "zero byte on response")
   `ABT_ASSERT_NEXT(a_eol_busy, clock, reset, req_valid && req_ready && req_line_end, !req_ready, "request taken right after end of line")
   `ABT_ASSERT_NOW(a_reset_quiet, clock, reset, $past(reset), !rsp_valid, "response valid right after reset")

endmodule

bind affine_block_transposition_core abt_checker u_abt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_line_end (req_chan.line_end),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_char_out (rsp_chan.char_out),
   .rsp_last     (rsp_chan.last)
);

>>> sim/affine_block_transposition_core_tb.sv
// ----------------------------------------------------------------------------
// Affine block transposition core testbench
// Sends line bytes and end-of-line markers through the request channel. Each
// transfer is mirrored in a behavioral copy of the block buffer, and that copy
// queues the permuted bytes and newlines it predicts. Every response transfer
// is checked against the oldest queued byte. The run covers directed corner
// lines, three random phases with different idle patterns, and a long
// response stall.
// ----------------------------------------------------------------------------
module affine_block_transposition_core_tb;
   import abt_pkg::*;

   localparam int MAX_BLOCK = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_CYCLES = 64;
   localparam int RUN_LIMIT = 5000000;

   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic              last;
   } cipher_byte_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   abt_req_if req_if ();
   abt_rsp_if rsp_if ();

   affine_block_transposition_core #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cipher_byte_type       cipher_out_q[$];
   logic [CHAR_W-1:0]     line_block [MAX_BLOCK];
   int                    fill_count;
   logic [BLEN_W-1:0]     blk_len_reg;
   logic [COEF_W-1:0]     mult_reg;
   logic [COEF_W-1:0]     offs_reg;

   int errors;
   int items_sent;
   int send_idle_pct;
   int rsp_idle_pct;
   int rsp_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("affine_block_transposition_core_tb: FAIL");
      $finish;
   end

   function automatic int block_size();
      if (blk_len_reg == '0) return 1;
      if (int'(blk_len_reg) > MAX_BLOCK) return MAX_BLOCK;
      return int'(blk_len_reg);
   endfunction

   function automatic void queue_permuted_block(input int n, input int filled);
      int                src;
      logic [CHAR_W-1:0] v;
      for (int j = 0; j < n; j++) begin
         src = (int'(mult_reg) * j + int'(offs_reg)) % n;
         v = (src < filled) ? line_block[src] : '0;
         if (v == '0) v = ZERO_SHOWN;
         cipher_out_q.push_back('{char_out: v, last: 1'b0});
      end
   endfunction

   function automatic void cipher_accept(input logic [CHAR_W-1:0] ch, input logic le);
      int              n;
      cipher_byte_type tail;
      n = block_size();
      if (fill_count >= n) fill_count = 0;
      if (!le) begin
         line_block[fill_count % MAX_BLOCK] = ch;
         fill_count++;
         if (fill_count >= n) begin
            queue_permuted_block(n, n);
            fill_count = 0;
            tail = cipher_out_q.pop_back();
            tail.last = 1'b1;
            cipher_out_q.push_back(tail);
         end
      end else begin
         if (fill_count > 0) queue_permuted_block(n, fill_count);
         fill_count = 0;
         cipher_out_q.push_back('{char_out: NEWLINE_CODE, last: 1'b1});
      end
   endfunction

   function automatic void cipher_config(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_BLOCK_LEN: begin
            blk_len_reg = data[BLEN_W-1:0];
            fill_count = 0;
         end
         CSR_MULT_A: mult_reg = data[COEF_W-1:0];
         CSR_OFFSET_B: offs_reg = data[COEF_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      cipher_config(idx, data);
      @(negedge clock);
   endtask

   task automatic send_item(input logic [CHAR_W-1:0] ch, input logic le);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.char_in <= ch;
      req_if.line_end <= le;
      do @(posedge clock); while (!req_if.ready);
      cipher_accept(ch, le);
      items_sent++;
      @(negedge clock);
   endtask

   // drop valid, wait out every pending byte, then let the core go quiet
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (cipher_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_line(input int max_len);
      int                len;
      logic [CHAR_W-1:0] ch;
      len = $urandom_range(max_len, 0);
      for (int i = 0; i < len; i++) begin
         ch = ($urandom_range(9) == 0) ? '0 : CHAR_W'($urandom_range(255));
         send_item(ch, 1'b0);
      end
      if ($urandom_range(9) != 0) send_item(CHAR_W'($urandom_range(255)), 1'b1);
   endtask

   task automatic test_unit_block();
      drain_results();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h5A, 1'b1);
   endtask

   task automatic test_affine_blocks();
      drain_results();
      write_reg(CSR_BLOCK_LEN, 8'd4);
      write_reg(CSR_MULT_A, 8'd3);
      write_reg(CSR_OFFSET_B, 8'd1);
      send_item(8'h01, 1'b0);
      send_item(8'h02, 1'b0);
      send_item(8'h03, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h41, 1'b0);
      send_item(8'h42, 1'b0);
      send_item(8'hA5, 1'b1);
   endtask

   task automatic test_len_limits();
      drain_results();
      write_reg(CSR_BLOCK_LEN, 8'hC0);
      send_item(8'h55, 1'b0);
      send_item(8'hAA, 1'b0);
      send_item(8'h00, 1'b1);
      drain_results();
      write_reg(CSR_BLOCK_LEN, 8'd63);
      write_reg(CSR_MULT_A, 8'd255);
      write_reg(CSR_OFFSET_B, 8'd0);
      send_item(8'h11, 1'b0);
      send_item(8'h22, 1'b0);
      send_item(8'h33, 1'b0);
      send_item(8'hFF, 1'b1);
   endtask

   task automatic test_zero_mult();
      drain_results();
      write_reg(CSR_BLOCK_LEN, 8'd5);
      write_reg(CSR_MULT_A, 8'd0);
      write_reg(CSR_OFFSET_B, 8'd255);
      for (int i = 0; i < 5; i++) send_item(CHAR_W'(8'h80 + i), 1'b0);
   endtask

   task automatic test_partial_drop();
      drain_results();
      write_reg(CSR_BLOCK_LEN, 8'd6);
      write_reg(CSR_MULT_A, 8'd1);
      write_reg(CSR_OFFSET_B, 8'd2);
      send_item(8'h61, 1'b0);
      send_item(8'h62, 1'b0);
      drain_results();
      write_reg(CSR_BLOCK_LEN, 8'd3);
      write_reg(CSR_UNUSED, 8'hFF);
      send_item(8'h0F, 1'b0);
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_random_lines(input int target, input int s_idle, input int r_idle,
                                    input logic [CSR_DATA_W-1:0] blen,
                                    input logic [CSR_DATA_W-1:0] mult,
                                    input logic [CSR_DATA_W-1:0] offs);
      int stop_at;
      int max_len;
      drain_results();
      send_idle_pct = s_idle;
      rsp_idle_pct = r_idle;
      write_reg(CSR_BLOCK_LEN, blen);
      write_reg(CSR_MULT_A, mult);
      write_reg(CSR_OFFSET_B, offs);
      max_len = 2 * block_size() + 2;
      if (max_len > 40) max_len = 40;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         if ($urandom_range(15) == 0) send_item(CHAR_W'($urandom_range(255)), 1'b1);
         else send_line(max_len);
      end
   endtask

   task automatic test_backpressure();
      drain_results();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      write_reg(CSR_BLOCK_LEN, 8'd8);
      write_reg(CSR_MULT_A, 8'd5);
      write_reg(CSR_OFFSET_B, 8'd7);
      rsp_hold_cycles = 300;
      for (int i = 0; i < 16; i++) send_item(CHAR_W'($urandom_range(255)), 1'b0);
      drain_results();
      send_line(12);
      send_line(12);
   endtask

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      cipher_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (cipher_out_q.size() == 0) begin
            report_mismatch("unexpected transfer, char_out", rsp_if.char_out, -1);
         end else begin
            want = cipher_out_q.pop_front();
            if (rsp_if.char_out !== want.char_out)
               report_mismatch("char_out", rsp_if.char_out, want.char_out);
            if (rsp_if.last !== want.last)
               report_mismatch("last", rsp_if.last, want.last);
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.char_in = '0;
      req_if.line_end = 1'b0;
      errors = 0;
      items_sent = 0;
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      rsp_hold_cycles = 0;
      fill_count = 0;
      blk_len_reg = BLEN_W'(1);
      mult_reg = COEF_W'(1);
      offs_reg = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_unit_block();
      test_affine_blocks();
      test_len_limits();
      test_zero_mult();
      test_partial_drop();
      test_random_lines(12, 17, 88, 8'd7, CSR_DATA_W'($urandom_range(255, 1)),
                        CSR_DATA_W'($urandom_range(255)));
      test_random_lines(16, 88, 17, 8'd33, 8'd255, 8'd255);
      test_random_lines(10, 0, 0, 8'd3, 8'd2, 8'd1);
      test_backpressure();

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("affine_block_transposition_core_tb: PASS");
      end else begin
         $display("affine_block_transposition_core_tb: FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/abt_pkg.sv
rtl/abt_req_if.sv
rtl/abt_rsp_if.sv
rtl/abt_ctrl.sv
rtl/abt_datapath.sv
rtl/affine_block_transposition_core.sv
rtl/abt_checker.sv
sim/affine_block_transposition_core_tb.sv
